// File: hw/rtl/vfcg_pkg.sv
// vfcg_pkg: shared types, sizes and constants of the frame change gate
// used by the interfaces, the checker and every module of the block but vfcg_ram
`default_nettype none

package vfcg_pkg;

  // store geometry: two banks of one frame each
  localparam int unsigned FRAME_PIXELS = 65536;
  localparam int unsigned STORE_DEPTH  = 2 * FRAME_PIXELS;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W        = $clog2(FRAME_PIXELS + 1);

  // field widths
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned PIX_W         = 3 * CHAN_W;
  localparam int unsigned SKIP_W        = 8;
  localparam int unsigned FRAME_NUM_W   = 32;
  localparam int unsigned COUNT_FIELD_W = 17;
  localparam int unsigned VERDICT_W     = 2;

  // fixed-point bt.601 weights, 14 fractional bits, round half up
  localparam int unsigned WEIGHT_R   = 4899;
  localparam int unsigned WEIGHT_G   = 9617;
  localparam int unsigned WEIGHT_B   = 1868;
  localparam int unsigned GRAY_ROUND = 8192;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam int unsigned SUM_W      = 22;

  // changed*10 against pixel total
  localparam int unsigned SCALE_W = POS_W + 4;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_KEEP    = 2'd0,
    VERDICT_SIMILAR = 2'd1,
    VERDICT_SKIP    = 2'd2
  } verdict_t;

  // frame data that travels with the last pixel
  typedef struct packed {
    logic [FRAME_NUM_W-1:0] frame_number;
    verdict_t               pre_verdict;
    logic [POS_W-1:0]       pixel_total;
    logic                   size_overflow;
  } frame_info_t;

  // one accepted pixel on its way to the compare stage
  typedef struct packed {
    logic             valid;
    logic             compare;
    logic             last;
    logic [PIX_W-1:0] pix;
    frame_info_t      info;
  } token_t;

  // frame decision sent back to the front
  typedef struct packed {
    logic valid;
    logic keep;
  } feedback_t;

  typedef struct packed {
    logic [FRAME_NUM_W-1:0]   frame_number;
    verdict_t                 verdict;
    logic [COUNT_FIELD_W-1:0] changed_pixels;
    logic [COUNT_FIELD_W-1:0] pixel_total;
    logic                     size_overflow;
  } result_t;

  function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] ptr);
    next_ptr = (ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vfcg_pixel_if.sv
// vfcg_pixel_if: valid/ready channel carrying one bgr pixel per transaction
// depends on vfcg_pkg for field widths
`default_nettype none

interface vfcg_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [vfcg_pkg::CHAN_W-1:0] blue;
  logic [vfcg_pkg::CHAN_W-1:0] green;
  logic [vfcg_pkg::CHAN_W-1:0] red;
  logic                        last_pixel;

  modport source (output valid, blue, green, red, last_pixel, input ready);
  modport sink (input valid, blue, green, red, last_pixel, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/vfcg_result_if.sv
// vfcg_result_if: valid/ready channel carrying one frame verdict per transaction
// depends on vfcg_pkg for field widths
`default_nettype none

interface vfcg_result_if;
  logic                               valid;
  logic                               ready;
  logic [vfcg_pkg::FRAME_NUM_W-1:0]   frame_number;
  logic [vfcg_pkg::VERDICT_W-1:0]     verdict;
  logic [vfcg_pkg::COUNT_FIELD_W-1:0] changed_pixels;
  logic [vfcg_pkg::COUNT_FIELD_W-1:0] pixel_total;
  logic                               size_overflow;

  modport source (output valid, frame_number, verdict, changed_pixels, pixel_total,
                  size_overflow, input ready);
  modport sink (input valid, frame_number, verdict, changed_pixels, pixel_total,
                size_overflow, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/vfcg_ram.sv
// vfcg_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module vfcg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vfcg_front.sv
// vfcg_front: accepts pixels, tracks frame state, addresses the two-bank store
// depends on vfcg_pkg and vfcg_pixel_if
`default_nettype none

module vfcg_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  vfcg_pixel_if.sink                               pixels,
  input  wire logic                                cfg_wr_en,
  input  wire logic [vfcg_pkg::SKIP_W-1:0]         cfg_wr_data,
  input  wire logic                                queue_room,
  input  wire vfcg_pkg::feedback_t                 fb,
  output vfcg_pkg::token_t                         tok,
  output logic                                     ram_we,
  output logic      [vfcg_pkg::STORE_AW-1:0]       ram_waddr,
  output logic      [vfcg_pkg::PIX_W-1:0]          ram_wdata,
  output logic                                     ram_re,
  output logic      [vfcg_pkg::STORE_AW-1:0]       ram_raddr
);

  logic [vfcg_pkg::POS_W-1:0]       pos;
  logic [vfcg_pkg::POS_W-1:0]       pos_inc;
  logic [vfcg_pkg::STORE_AW-1:0]    pos_addr;
  logic [vfcg_pkg::STORE_AW-1:0]    pos_addr_hi;
  logic                             bank;
  logic                             have_ref;
  logic                             overflow_seen;
  logic                             waiting;
  logic [vfcg_pkg::SKIP_W-1:0]      skip_rem;
  logic [vfcg_pkg::SKIP_W-1:0]      skip_count;
  logic [vfcg_pkg::FRAME_NUM_W-1:0] frame_counter;
  logic                             fire;
  logic                             in_range;
  logic                             comparing;
  vfcg_pkg::verdict_t               pre_verdict;

  // hold off after a frame end until its verdict is back, and while the result queue is full
  assign pixels.ready = !waiting && queue_room;
  assign fire         = pixels.valid && pixels.ready;

  assign in_range    = pos < vfcg_pkg::POS_W'(vfcg_pkg::FRAME_PIXELS);
  assign comparing   = have_ref && (skip_rem == '0);
  assign pos_inc     = pos + 1'b1;
  assign pos_addr    = vfcg_pkg::STORE_AW'(pos);
  assign pos_addr_hi = pos_addr + vfcg_pkg::STORE_AW'(vfcg_pkg::FRAME_PIXELS);

  // frame class known before any comparison
  always_comb begin
    if (!have_ref) begin
      pre_verdict = vfcg_pkg::VERDICT_KEEP;
    end else if (skip_rem != '0) begin
      pre_verdict = vfcg_pkg::VERDICT_SKIP;
    end else begin
      pre_verdict = vfcg_pkg::VERDICT_SIMILAR;
    end
  end

  // candidate goes to the bank opposite the reference
  assign ram_we    = fire && in_range;
  assign ram_waddr = bank ? pos_addr : pos_addr_hi;
  assign ram_wdata = {pixels.red, pixels.green, pixels.blue};
  assign ram_re    = fire && in_range && comparing;
  assign ram_raddr = bank ? pos_addr_hi : pos_addr;

  // token register, lines up with the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= fire;
    end
    tok.compare                <= in_range && comparing;
    tok.last                   <= pixels.last_pixel;
    tok.pix                    <= {pixels.red, pixels.green, pixels.blue};
    tok.info.frame_number      <= frame_counter;
    tok.info.pre_verdict       <= pre_verdict;
    tok.info.pixel_total       <= in_range ? pos_inc : pos;
    tok.info.size_overflow     <= overflow_seen || !in_range;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      bank          <= 1'b0;
      have_ref      <= 1'b0;
      overflow_seen <= 1'b0;
      waiting       <= 1'b0;
      skip_rem      <= '0;
      skip_count    <= '0;
      frame_counter <= '0;
    end else begin
      if (cfg_wr_en) begin
        skip_count <= cfg_wr_data;
      end
      if (fire) begin
        if (in_range) begin
          pos <= pos_inc;
        end else begin
          overflow_seen <= 1'b1;
        end
        if (pixels.last_pixel) begin
          pos           <= '0;
          overflow_seen <= 1'b0;
          frame_counter <= frame_counter + 1'b1;
          waiting       <= 1'b1;
          if (pre_verdict == vfcg_pkg::VERDICT_SKIP) begin
            skip_rem <= skip_rem - 1'b1;
          end
        end
      end
      // kept frame becomes the reference
      if (fb.valid) begin
        waiting <= 1'b0;
        if (fb.keep) begin
          bank     <= !bank;
          have_ref <= 1'b1;
          skip_rem <= skip_count;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vfcg_compare.sv
// vfcg_compare: gray difference per pixel, changed count and frame verdict
// depends on vfcg_pkg
`default_nettype none

module vfcg_compare (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vfcg_pkg::token_t              tok,
  input  wire logic [vfcg_pkg::PIX_W-1:0]    ref_pix,
  output vfcg_pkg::feedback_t                fb,
  output logic                               push,
  output vfcg_pkg::result_t                  rec
);

  function automatic logic [vfcg_pkg::CHAN_W-1:0] abs_diff(
    input logic [vfcg_pkg::CHAN_W-1:0] a,
    input logic [vfcg_pkg::CHAN_W-1:0] b
  );
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  logic [vfcg_pkg::CHAN_W-1:0]  d_b;
  logic [vfcg_pkg::CHAN_W-1:0]  d_g;
  logic [vfcg_pkg::CHAN_W-1:0]  d_r;
  logic [vfcg_pkg::SUM_W-1:0]   gray_sum;
  logic                         changed;
  logic                         s2_valid;
  logic                         s2_changed;
  logic                         s2_last;
  vfcg_pkg::frame_info_t        s2_info;
  logic [vfcg_pkg::POS_W-1:0]   count;
  logic [vfcg_pkg::POS_W-1:0]   total;
  logic                         end_valid;
  logic [vfcg_pkg::POS_W-1:0]   end_count;
  vfcg_pkg::frame_info_t        end_info;
  logic [vfcg_pkg::SCALE_W-1:0] scaled;
  vfcg_pkg::verdict_t           verdict;

  // per-channel absolute difference and weighted gray sum
  assign d_b = abs_diff(tok.pix[vfcg_pkg::CHAN_W-1:0], ref_pix[vfcg_pkg::CHAN_W-1:0]);
  assign d_g = abs_diff(tok.pix[2*vfcg_pkg::CHAN_W-1:vfcg_pkg::CHAN_W],
                        ref_pix[2*vfcg_pkg::CHAN_W-1:vfcg_pkg::CHAN_W]);
  assign d_r = abs_diff(tok.pix[3*vfcg_pkg::CHAN_W-1:2*vfcg_pkg::CHAN_W],
                        ref_pix[3*vfcg_pkg::CHAN_W-1:2*vfcg_pkg::CHAN_W]);

  assign gray_sum = vfcg_pkg::SUM_W'(d_r) * vfcg_pkg::SUM_W'(vfcg_pkg::WEIGHT_R)
                  + vfcg_pkg::SUM_W'(d_g) * vfcg_pkg::SUM_W'(vfcg_pkg::WEIGHT_G)
                  + vfcg_pkg::SUM_W'(d_b) * vfcg_pkg::SUM_W'(vfcg_pkg::WEIGHT_B)
                  + vfcg_pkg::SUM_W'(vfcg_pkg::GRAY_ROUND);

  assign changed = tok.compare && ((gray_sum >> vfcg_pkg::GRAY_SHIFT) != '0);

  // stage 2: changed flag register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= tok.valid;
    end
    s2_changed <= changed;
    s2_last    <= tok.last;
    s2_info    <= tok.info;
  end

  assign total = count + vfcg_pkg::POS_W'(s2_changed);

  // changed pixel counter, cleared at each frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      end_valid <= 1'b0;
    end else begin
      end_valid <= s2_valid && s2_last;
      if (s2_valid) begin
        count <= s2_last ? '0 : total;
      end
    end
    end_count <= total;
    end_info  <= s2_info;
  end

  // stage 3: threshold changed*10 > pixel total
  assign scaled = (vfcg_pkg::SCALE_W'(end_count) << 3) + (vfcg_pkg::SCALE_W'(end_count) << 1);

  always_comb begin
    unique case (end_info.pre_verdict)
      vfcg_pkg::VERDICT_KEEP: verdict = vfcg_pkg::VERDICT_KEEP;
      vfcg_pkg::VERDICT_SKIP: verdict = vfcg_pkg::VERDICT_SKIP;
      vfcg_pkg::VERDICT_SIMILAR: begin
        verdict = (scaled > vfcg_pkg::SCALE_W'(end_info.pixel_total)) ?
                  vfcg_pkg::VERDICT_KEEP : vfcg_pkg::VERDICT_SIMILAR;
      end
      default: verdict = vfcg_pkg::VERDICT_SIMILAR;
    endcase
  end

  assign fb.valid = end_valid;
  assign fb.keep  = (verdict == vfcg_pkg::VERDICT_KEEP);
  assign push     = end_valid;

  assign rec.frame_number   = end_info.frame_number;
  assign rec.verdict        = verdict;
  assign rec.changed_pixels = vfcg_pkg::COUNT_FIELD_W'(end_count);
  assign rec.pixel_total    = vfcg_pkg::COUNT_FIELD_W'(end_info.pixel_total);
  assign rec.size_overflow  = end_info.size_overflow;

endmodule

`default_nettype wire

// File: hw/rtl/vfcg_queue.sv
// vfcg_queue: short result queue that drives the output channel
// depends on vfcg_pkg and vfcg_result_if
`default_nettype none

module vfcg_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire vfcg_pkg::result_t rec,
  output logic                   room,
  vfcg_result_if.source          results
);

  vfcg_pkg::result_t                entries [vfcg_pkg::QUEUE_DEPTH];
  logic [vfcg_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [vfcg_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [vfcg_pkg::QUEUE_CNT_W-1:0] count;
  logic                             pop;

  assign room = count < vfcg_pkg::QUEUE_CNT_W'(vfcg_pkg::QUEUE_DEPTH);
  assign pop  = results.valid && results.ready;

  // head entry on the channel
  assign results.valid          = count != '0;
  assign results.frame_number   = entries[rd_ptr].frame_number;
  assign results.verdict        = entries[rd_ptr].verdict;
  assign results.changed_pixels = entries[rd_ptr].changed_pixels;
  assign results.pixel_total    = entries[rd_ptr].pixel_total;
  assign results.size_overflow  = entries[rd_ptr].size_overflow;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= vfcg_pkg::next_ptr(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= vfcg_pkg::next_ptr(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/video_frame_change_gate_core.sv
// Frame change gate: pixel valid/ready in, one verdict per frame out.
// Throughput: one pixel per cycle within a frame while the result queue has room;
// each frame end holds ready low while the verdict returns to the front (compare
// stages and bank swap); the verdict is then offered from the result queue.
// Reset: synchronous active-high rst clears all control and counters; the
// two-bank frame store is not cleared and needs no clearing pass.
`default_nettype none

module video_frame_change_gate_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [vfcg_pkg::SKIP_W-1:0] cfg_wr_data,
  vfcg_pixel_if.sink                       pixels,
  vfcg_result_if.source                    results
);

  vfcg_pkg::token_t              tok;
  vfcg_pkg::feedback_t           fb;
  vfcg_pkg::result_t             rec;
  logic                          push;
  logic                          room;
  logic                          ram_we;
  logic [vfcg_pkg::STORE_AW-1:0] ram_waddr;
  logic [vfcg_pkg::PIX_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [vfcg_pkg::STORE_AW-1:0] ram_raddr;
  logic [vfcg_pkg::PIX_W-1:0]    ram_rdata;

  // pixel intake and store addressing
  vfcg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixels      (pixels),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .queue_room  (room),
    .fb          (fb),
    .tok         (tok),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  // two-bank frame store
  vfcg_ram #(
    .WIDTH (vfcg_pkg::PIX_W),
    .DEPTH (vfcg_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // difference, count and verdict
  vfcg_compare u_compare (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok),
    .ref_pix (ram_rdata),
    .fb      (fb),
    .push    (push),
    .rec     (rec)
  );

  // result queue to the output channel
  vfcg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rec     (rec),
    .room    (room),
    .results (results)
  );

endmodule

`default_nettype wire

// File: hw/rtl/vfcg_checker.sv
// vfcg_checker: port-level assertions for the frame change gate, bound to the top
// depends on vfcg_pkg
`default_nettype none

module vfcg_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 pix_valid,
  input wire logic                                 pix_ready,
  input wire logic                                 pix_last,
  input wire logic                                 res_valid,
  input wire logic                                 res_ready,
  input wire logic [vfcg_pkg::FRAME_NUM_W-1:0]     res_frame,
  input wire logic [vfcg_pkg::VERDICT_W-1:0]       res_verdict,
  input wire logic [vfcg_pkg::COUNT_FIELD_W-1:0]   res_changed,
  input wire logic [vfcg_pkg::COUNT_FIELD_W-1:0]   res_total
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_frame) && $stable(res_verdict))
    else $error("stalled result changed");

  // a frame end pauses intake while its verdict returns
  assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && pix_last |=> !pix_ready)
    else $error("pixel taken right after a frame end");

  // changed pixels never exceed the stored pixels
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_changed <= res_total)
    else $error("changed count above pixel total");

  // skipped frames are never compared
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_verdict == vfcg_pkg::VERDICT_SKIP) |-> res_changed == '0)
    else $error("skipped frame reports changed pixels");

endmodule

bind video_frame_change_gate_core vfcg_checker u_vfcg_checker (
  .clk         (clk),
  .rst         (rst),
  .pix_valid   (pixels.valid),
  .pix_ready   (pixels.ready),
  .pix_last    (pixels.last_pixel),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .res_frame   (results.frame_number),
  .res_verdict (results.verdict),
  .res_changed (results.changed_pixels),
  .res_total   (results.pixel_total)
);

`default_nettype wire

// File: verif/tb_video_frame_change_gate_core.sv
// testbench for the frame change gate: drives pixel frames, predicts one verdict per frame
// and checks every result transaction against it; depends on vfcg_pkg and both channel
// interfaces from the rtl tree
`default_nettype none

module tb_video_frame_change_gate_core;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 20;

  // per-frame verdict predictor with its own copy of the two-bank store
  class change_verdicts;
    logic [vfcg_pkg::PIX_W-1:0] frame_mem [vfcg_pkg::STORE_DEPTH];
    int unsigned written_len [2];
    bit ref_bank = 1'b0;
    bit have_ref = 1'b0;
    logic [vfcg_pkg::SKIP_W-1:0] skip_left = '0;
    logic [vfcg_pkg::SKIP_W-1:0] skip_cfg = '0;
    int unsigned pos = 0;
    int unsigned changed = 0;
    logic [vfcg_pkg::FRAME_NUM_W-1:0] frame_idx = '0;
    bit overflow = 1'b0;
    vfcg_pkg::result_t awaited_verdicts [$];
    int errors = 0;

    function void set_skip(logic [vfcg_pkg::SKIP_W-1:0] value);
      skip_cfg = value;
    endfunction

    function bit comparing();
      return have_ref && skip_left == 0;
    endfunction

    function int unsigned ref_extent();
      return written_len[ref_bank];
    endfunction

    function logic [vfcg_pkg::PIX_W-1:0] ref_pixel(int unsigned idx);
      return frame_mem[(ref_bank ? vfcg_pkg::FRAME_PIXELS : 0) + idx];
    endfunction

    function int pending();
      return awaited_verdicts.size();
    endfunction

    static function int unsigned chan_diff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? 32'(a - b) : 32'(b - a);
    endfunction

    // bt.601 gray of the per-channel absolute difference, round half up
    static function bit gray_moved(logic [vfcg_pkg::PIX_W-1:0] a,
                                   logic [vfcg_pkg::PIX_W-1:0] b);
      int unsigned dr, dg, db, sum;
      dr = chan_diff(a[23:16], b[23:16]);
      dg = chan_diff(a[15:8], b[15:8]);
      db = chan_diff(a[7:0], b[7:0]);
      sum = vfcg_pkg::WEIGHT_R * dr + vfcg_pkg::WEIGHT_G * dg + vfcg_pkg::WEIGHT_B * db
          + vfcg_pkg::GRAY_ROUND;
      return (sum >> vfcg_pkg::GRAY_SHIFT) != 0;
    endfunction

    // one accepted pixel; a frame end queues the expected verdict
    function void take_pixel(logic [vfcg_pkg::PIX_W-1:0] pix, bit last);
      bit cand;
      bit cmp;
      int unsigned cand_base;
      int unsigned ref_base;
      vfcg_pkg::result_t want;
      cand = ~ref_bank;
      cmp = comparing();
      cand_base = cand ? vfcg_pkg::FRAME_PIXELS : 0;
      ref_base = ref_bank ? vfcg_pkg::FRAME_PIXELS : 0;
      if (pos < vfcg_pkg::FRAME_PIXELS) begin
        if (cmp && gray_moved(pix, frame_mem[ref_base + pos])) changed++;
        frame_mem[cand_base + pos] = pix;
        if (pos + 1 > written_len[cand]) written_len[cand] = pos + 1;
        pos++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;

      want.frame_number = frame_idx;
      if (!have_ref) begin
        want.verdict = vfcg_pkg::VERDICT_KEEP;
      end else if (skip_left != 0) begin
        want.verdict = vfcg_pkg::VERDICT_SKIP;
        skip_left--;
      end else if (changed * 10 > pos) begin
        want.verdict = vfcg_pkg::VERDICT_KEEP;
      end else begin
        want.verdict = vfcg_pkg::VERDICT_SIMILAR;
      end
      // kept frame becomes the reference
      if (want.verdict == vfcg_pkg::VERDICT_KEEP) begin
        ref_bank = cand;
        have_ref = 1'b1;
        skip_left = skip_cfg;
      end
      want.changed_pixels = changed[vfcg_pkg::COUNT_FIELD_W-1:0];
      want.pixel_total = pos[vfcg_pkg::COUNT_FIELD_W-1:0];
      want.size_overflow = overflow;
      awaited_verdicts.push_back(want);

      frame_idx++;
      pos = 0;
      changed = 0;
      overflow = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task compare_field(string field, logic [31:0] got, logic [31:0] want,
                       logic [31:0] frame);
      if (got !== want)
        report($sformatf("frame %0d %s: got %0h expected %0h", frame, field, got, want));
    endtask

    // one accepted result against the oldest expected verdict
    task check_verdict(vfcg_pkg::result_t got);
      vfcg_pkg::result_t want;
      if (awaited_verdicts.size() == 0) begin
        report($sformatf("result for frame %0d with no frame pending", got.frame_number));
        return;
      end
      want = awaited_verdicts.pop_front();
      compare_field("frame_number", got.frame_number, want.frame_number, want.frame_number);
      compare_field("verdict", 32'(got.verdict), 32'(want.verdict), want.frame_number);
      compare_field("changed_pixels", 32'(got.changed_pixels), 32'(want.changed_pixels),
                    want.frame_number);
      compare_field("pixel_total", 32'(got.pixel_total), 32'(want.pixel_total),
                    want.frame_number);
      compare_field("size_overflow", 32'(got.size_overflow), 32'(want.size_overflow),
                    want.frame_number);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [vfcg_pkg::SKIP_W-1:0] cfg_wr_data;
  int sender_idle;
  int recv_stall;
  int unsigned items_sent;
  int unsigned quiet_cycles = 0;
  change_verdicts verdicts;

  vfcg_pixel_if pix_ch ();
  vfcg_result_if res_ch ();

  video_frame_change_gate_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pixels      (pix_ch),
    .results     (res_ch)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99, 0) >= recv_stall);
  end

  // check each result transaction
  always @(posedge clk) begin : watch_results
    vfcg_pkg::result_t seen;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.frame_number = res_ch.frame_number;
      seen.verdict = vfcg_pkg::verdict_t'(res_ch.verdict);
      seen.changed_pixels = res_ch.changed_pixels;
      seen.pixel_total = res_ch.pixel_total;
      seen.size_overflow = res_ch.size_overflow;
      verdicts.check_verdict(seen);
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one pixel transaction, with random idle cycles ahead of it
  task drive_pixel(logic [vfcg_pkg::PIX_W-1:0] pix, bit last);
    while ($urandom_range(99, 0) < sender_idle) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.blue <= pix[7:0];
    pix_ch.green <= pix[15:8];
    pix_ch.red <= pix[23:16];
    pix_ch.last_pixel <= last;
    do @(posedge clk); while (!pix_ch.ready);
    verdicts.take_pixel(pix, last);
    items_sent++;
  endtask

  function automatic logic [vfcg_pkg::PIX_W-1:0] any_pixel();
    case ($urandom_range(15, 0))
      0: return '0;
      1: return '1;
      default: return vfcg_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c, int unsigned d);
    if (c + d <= 255 && (c < d || $urandom_range(1, 0))) return 8'(c + d);
    return 8'(c - d);
  endfunction

  // small red/blue offsets that keep the gray difference at zero
  function automatic logic [vfcg_pkg::PIX_W-1:0] near_copy(logic [vfcg_pkg::PIX_W-1:0] refp);
    int unsigned dr, db;
    dr = $urandom_range(1, 0);
    db = dr ? $urandom_range(1, 0) : $urandom_range(4, 0);
    return {nudge(refp[23:16], dr), refp[15:8], nudge(refp[7:0], db)};
  endfunction

  // one frame; the first n_force pixels change, the rest change with pct percent
  task send_frame(int unsigned len, int unsigned n_force, int unsigned pct);
    bit cmp;
    logic [vfcg_pkg::PIX_W-1:0] refp;
    logic [vfcg_pkg::PIX_W-1:0] pix;
    cmp = verdicts.comparing();
    if (cmp && len > verdicts.ref_extent()) len = verdicts.ref_extent();
    for (int unsigned i = 0; i < len; i++) begin
      if (cmp) begin
        refp = verdicts.ref_pixel(i);
        // flipping the green msb always moves the gray value
        if (i < n_force || $urandom_range(99, 0) < pct)
          pix = refp ^ (vfcg_pkg::PIX_W'($urandom) | 24'h008000);
        else
          pix = near_copy(refp);
      end else begin
        pix = any_pixel();
      end
      drive_pixel(pix, i == len - 1);
    end
  endtask

  task drain_pause();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts.pending() != 0);
  endtask

  task settle();
    drain_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_skip(logic [vfcg_pkg::SKIP_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    verdicts.set_skip(value);
  endtask

  // random frames: compared ones near the keep threshold or at random change rates, uncompared ones mostly short
  task run_phase(int unsigned n_pixels);
    int unsigned start;
    int unsigned len;
    start = items_sent;
    while (items_sent - start < n_pixels) begin
      if (verdicts.comparing()) begin
        len = verdicts.ref_extent();
        if (len > 24) len = 24;
        len = $urandom_range(len, 1);
        case ($urandom_range(2, 0))
          0: send_frame(len, len / 10 + $urandom_range(1, 0), 0);
          1: send_frame(len, 0, 100);
          default: send_frame(len, 0, $urandom_range(30, 0));
        endcase
      end else begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(30, 4) : $urandom_range(3, 1);
        send_frame(len, 0, 0);
      end
      if ($urandom_range(19, 0) == 0) drain_pause();
    end
  endtask

  initial begin
    verdicts = new();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.blue = '0;
    pix_ch.green = '0;
    pix_ch.red = '0;
    pix_ch.last_pixel = 1'b0;
    sender_idle = 0;
    recv_stall = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_skip(0);

    // first frame is always kept
    send_frame(16, 0, 0);
    // one changed in ten stays similar, two in ten is kept
    send_frame(10, 1, 0);
    send_frame(10, 2, 0);
    send_frame(1, 1, 0);
    send_frame(8, 0, 100);
    send_frame(8, 0, 0);
    // kept frame followed by skipped frames
    settle();
    write_skip(2);
    send_frame(3, 0, 100);
    send_frame(1, 0, 0);
    send_frame(5, 0, 0);
    send_frame(4, 0, 0);

    settle();
    write_skip(0);
    run_phase(150);

    settle();
    write_skip(1);
    sender_idle = 77;
    run_phase(150);

    settle();
    write_skip(255);
    sender_idle = 0;
    recv_stall = 77;
    run_phase(450);

    settle();
    write_skip($urandom_range(20, 3));
    sender_idle = 18;
    recv_stall = 18;
    run_phase(150);

    drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdicts.pending() != 0)
      verdicts.report($sformatf("%0d verdicts never arrived", verdicts.pending()));
    if (verdicts.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/vfcg_pkg.sv
hw/rtl/vfcg_pixel_if.sv
hw/rtl/vfcg_result_if.sv
hw/rtl/vfcg_ram.sv
hw/rtl/vfcg_front.sv
hw/rtl/vfcg_compare.sv
hw/rtl/vfcg_queue.sv
hw/rtl/video_frame_change_gate_core.sv
hw/rtl/vfcg_checker.sv
verif/tb_video_frame_change_gate_core.sv
